FILE: rtl/core/cana_pkg.sv
// Shared types, codes and helper functions for the CAN node alias negotiator.
// No dependencies; imported by the top level and by its checker.
package cana_pkg;

    localparam int NODE_W  = 48;
    localparam int ALIAS_W = 12;
    localparam int STORE_W = 16;
    localparam int TICK_W  = 8;
    localparam int OP_W    = 3;
    localparam int KIND_W  = 3;
    localparam int CFG_IW  = 2;

    // result queue
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = 2;
    localparam int Q_CW    = 3;

    localparam logic [NODE_W-1:0]  SEED_ADD     = 48'h1B0C_A37A_4BA9;
    localparam logic [STORE_W-1:0] STORE_NONE_A = 16'h0000;
    localparam logic [STORE_W-1:0] STORE_NONE_B = 16'hFFFF;
    localparam logic [TICK_W-1:0]  TICK_MAX     = 8'hFF;
    localparam logic [TICK_W-1:0]  WAIT_RESET   = 8'd7;

    // input op codes
    localparam logic [OP_W-1:0] OP_POWER_ON      = 3'd0;
    localparam logic [OP_W-1:0] OP_LATE_CONFLICT = 3'd1;
    localparam logic [OP_W-1:0] OP_SLOT_FREE     = 3'd2;
    localparam logic [OP_W-1:0] OP_FRAME_RX      = 3'd3;
    localparam logic [OP_W-1:0] OP_TICK          = 3'd4;

    // frame kinds
    localparam logic [KIND_W-1:0] KIND_CIM0 = 3'd0;
    localparam logic [KIND_W-1:0] KIND_CIM3 = 3'd3;
    localparam logic [KIND_W-1:0] KIND_RID  = 3'd4;
    localparam logic [KIND_W-1:0] KIND_AMD  = 3'd5;

    // negotiation phases
    localparam logic [1:0] PH_IDLE     = 2'd0;
    localparam logic [1:0] PH_ANNOUNCE = 2'd1;
    localparam logic [1:0] PH_WAIT     = 2'd2;
    localparam logic [1:0] PH_CLAIMED  = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IW-1:0] CFG_NODE_ID      = 2'd0;
    localparam logic [CFG_IW-1:0] CFG_STORED_ALIAS = 2'd1;
    localparam logic [CFG_IW-1:0] CFG_WAIT_TICKS   = 2'd2;

    typedef struct packed {
        logic [KIND_W-1:0]  frame_kind;
        logic [ALIAS_W-1:0] source_alias;
        logic [NODE_W-1:0]  payload;
        logic               save_request;
        logic [NODE_W-1:0]  save_seed;
        logic               last;
    } t_result;

    // XOR of the four 12-bit groups
    function automatic logic [ALIAS_W-1:0] fold_alias(input logic [NODE_W-1:0] s);
        return s[47:36] ^ s[35:24] ^ s[23:12] ^ s[11:0];
    endfunction

    // seed * 513 + SEED_ADD, modulo 2^48
    function automatic logic [NODE_W-1:0] seed_step(input logic [NODE_W-1:0] s);
        return s + {s[NODE_W-10:0], 9'd0} + SEED_ADD;
    endfunction

endpackage

FILE: rtl/core/can_node_alias_negotiator.sv
// CAN node alias negotiator: alias selection, CIM announcement, RID/AMD claim.
// Depends on cana_pkg (codes, result struct, seed and fold functions).
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+----------------------------------
//  in      | input     | i_in_valid / o_in_ready    | i_op, i_rx_alias
//  out     | output    | o_out_valid / i_out_ready  | frame_kind, alias, payload, save..
//  cfg     | input     | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// One event per cycle: an accepted event is held in the input register, then
// its state update and its zero to two results land in a four-entry result queue.
// Results leave one per cycle while i_out_ready is high; a timer tick that claims
// pushes both (RID + AMD). The input stage holds while fewer than two queue entries are free.
// Synchronous active-low reset clears state and queue; config is always ready.
module can_node_alias_negotiator
    import cana_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [OP_W-1:0]      i_op,
    input  logic [ALIAS_W-1:0]   i_rx_alias,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [KIND_W-1:0]    o_frame_kind,
    output logic [ALIAS_W-1:0]   o_source_alias,
    output logic [NODE_W-1:0]    o_payload,
    output logic                 o_save_request,
    output logic [NODE_W-1:0]    o_save_seed,
    output logic                 o_last,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IW-1:0]    i_cfg_index,
    input  logic [NODE_W-1:0]    i_cfg_data
);

    // configuration
    logic [NODE_W-1:0]  r_node_id;
    logic [STORE_W-1:0] r_stored_alias;
    logic [TICK_W-1:0]  r_wait_ticks;

    // input register
    logic               r_in_vld;
    logic [OP_W-1:0]    r_op;
    logic [ALIAS_W-1:0] r_rx_alias;

    // negotiation state
    logic [1:0]         r_phase,      n_phase;
    logic [1:0]         r_next_cim,   n_next_cim;
    logic [TICK_W-1:0]  r_tick_count, n_tick_count;
    logic [NODE_W-1:0]  r_seed,       n_seed;
    logic [ALIAS_W-1:0] r_alias,      n_alias;
    logic               r_dirty,      n_dirty;

    // result queue
    t_result            r_q [Q_DEPTH];
    logic [Q_AW-1:0]    r_head, r_tail;
    logic [Q_CW-1:0]    r_count;

    logic               in_xfer, out_xfer, fire;
    logic [1:0]         push_cnt;
    t_result            res0, res1;
    logic [NODE_W-1:0]  step_seed;
    logic [TICK_W-1:0]  tick_inc;
    logic [ALIAS_W-1:0] cim_slice;

    assign o_cfg_ready = 1'b1;
    assign out_xfer    = o_out_valid && i_out_ready;
    assign fire        = r_in_vld && (r_count <= Q_CW'(Q_DEPTH - 2));
    assign o_in_ready  = !r_in_vld || fire;
    assign in_xfer     = i_in_valid && o_in_ready;

    assign step_seed = seed_step(r_seed);
    assign tick_inc  = (r_tick_count == TICK_MAX) ? r_tick_count : r_tick_count + 8'd1;

    always_comb begin
        case (r_next_cim)
            2'd0:    cim_slice = r_node_id[47:36];
            2'd1:    cim_slice = r_node_id[35:24];
            2'd2:    cim_slice = r_node_id[23:12];
            default: cim_slice = r_node_id[11:0];
        endcase
    end

    always_comb begin
        n_phase      = r_phase;
        n_next_cim   = r_next_cim;
        n_tick_count = r_tick_count;
        n_seed       = r_seed;
        n_alias      = r_alias;
        n_dirty      = r_dirty;
        push_cnt     = 2'd0;

        res0.frame_kind   = {1'b0, r_next_cim};
        res0.source_alias = r_alias;
        res0.payload      = {{(NODE_W-ALIAS_W){1'b0}}, cim_slice};
        res0.save_request = 1'b0;
        res0.save_seed    = r_seed;
        res0.last         = 1'b1;

        res1.frame_kind   = KIND_AMD;
        res1.source_alias = r_alias;
        res1.payload      = r_node_id;
        res1.save_request = 1'b0;
        res1.save_seed    = r_seed;
        res1.last         = 1'b1;

        case (r_op)
            OP_POWER_ON: begin
                n_seed = r_node_id;
                if (r_stored_alias == STORE_NONE_A || r_stored_alias == STORE_NONE_B) begin
                    n_alias = fold_alias(r_node_id);
                    n_dirty = 1'b1;
                end else begin
                    n_alias = r_stored_alias[ALIAS_W-1:0];
                    n_dirty = 1'b0;
                end
                n_phase      = PH_ANNOUNCE;
                n_next_cim   = 2'd0;
                n_tick_count = '0;
            end
            OP_LATE_CONFLICT: begin
                n_seed       = step_seed;
                n_alias      = fold_alias(step_seed);
                n_dirty      = 1'b1;
                n_phase      = PH_ANNOUNCE;
                n_next_cim   = 2'd0;
                n_tick_count = '0;
            end
            OP_SLOT_FREE: begin
                if (r_phase == PH_ANNOUNCE) begin
                    push_cnt = 2'd1;
                    if (r_next_cim == 2'd3) begin
                        n_phase      = PH_WAIT;
                        n_tick_count = '0;
                    end else begin
                        n_next_cim = r_next_cim + 2'd1;
                    end
                end
            end
            OP_FRAME_RX: begin
                if ((r_phase == PH_ANNOUNCE || r_phase == PH_WAIT) && r_rx_alias == r_alias) begin
                    n_seed       = step_seed;
                    n_alias      = fold_alias(step_seed);
                    n_dirty      = 1'b1;
                    n_phase      = PH_ANNOUNCE;
                    n_next_cim   = 2'd0;
                    n_tick_count = '0;
                end
            end
            OP_TICK: begin
                if (r_phase == PH_WAIT) begin
                    n_tick_count = tick_inc;
                    if (tick_inc >= r_wait_ticks) begin
                        res0.frame_kind   = KIND_RID;
                        res0.payload      = '0;
                        res0.save_request = r_dirty;
                        res0.last         = 1'b0;
                        push_cnt          = 2'd2;
                        n_phase           = PH_CLAIMED;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_id      <= '0;
            r_stored_alias <= '0;
            r_wait_ticks   <= WAIT_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_NODE_ID:      r_node_id      <= i_cfg_data;
                CFG_STORED_ALIAS: r_stored_alias <= i_cfg_data[STORE_W-1:0];
                CFG_WAIT_TICKS:   r_wait_ticks   <= i_cfg_data[TICK_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // input register: load on transfer, drop once processed
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else begin
            r_in_vld <= in_xfer || (r_in_vld && !fire);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_op       <= i_op;
            r_rx_alias <= i_rx_alias;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_next_cim   <= '0;
            r_tick_count <= '0;
            r_seed       <= '0;
            r_alias      <= '0;
            r_dirty      <= 1'b0;
        end else if (fire) begin
            r_phase      <= n_phase;
            r_next_cim   <= n_next_cim;
            r_tick_count <= n_tick_count;
            r_seed       <= n_seed;
            r_alias      <= n_alias;
            r_dirty      <= n_dirty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            if (out_xfer) begin
                r_head <= r_head + Q_AW'(1);
            end
            if (fire) begin
                r_tail <= r_tail + Q_AW'(push_cnt);
            end
            r_count <= r_count + (fire ? Q_CW'(push_cnt) : Q_CW'(0)) - Q_CW'(out_xfer);
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && push_cnt != 2'd0) begin
            r_q[r_tail] <= res0;
        end
        if (fire && push_cnt == 2'd2) begin
            r_q[r_tail + Q_AW'(1)] <= res1;
        end
    end

    assign o_out_valid    = (r_count != '0);
    assign o_frame_kind   = r_q[r_head].frame_kind;
    assign o_source_alias = r_q[r_head].source_alias;
    assign o_payload      = r_q[r_head].payload;
    assign o_save_request = r_q[r_head].save_request;
    assign o_save_seed    = r_q[r_head].save_seed;
    assign o_last         = r_q[r_head].last;

endmodule

FILE: rtl/core/cana_checker.sv
// Port-level checks for the CAN node alias negotiator, bound to the top level.
// Depends on cana_pkg for frame kind codes.
module cana_checker
    import cana_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_out_valid,
    input logic                 i_out_ready,
    input logic [KIND_W-1:0]    o_frame_kind,
    input logic [ALIAS_W-1:0]   o_source_alias,
    input logic [NODE_W-1:0]    o_payload,
    input logic                 o_save_request,
    input logic [NODE_W-1:0]    o_save_seed,
    input logic                 o_last
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_frame_kind)
            && $stable(o_payload) && $stable(o_source_alias) && $stable(o_save_seed))
        else $error("stalled result changed");

    // reset empties the result queue
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result pending after reset");

    // only RID carries a save request
    a_save_on_rid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_save_request |-> o_frame_kind == KIND_RID)
        else $error("save request outside RID");

    // RID is always followed by AMD, so it is never the last result
    a_last_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_last == (o_frame_kind != KIND_RID))
        else $error("last flag mismatch");

    // CIM frames carry a 12-bit slice only
    a_cim_slice: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_frame_kind <= KIND_CIM3 |-> o_payload[47:12] == '0)
        else $error("CIM payload wider than a slice");

endmodule

bind can_node_alias_negotiator cana_checker u_cana_checker (.*);
